// ----- hw/rtl/i2c_master_register_access_macros.svh -----
// Assertion macros for the I2C master register access RTL.
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define I2CM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define I2CM_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define I2CM_ASSERT(label, clk, rst_n, prop, msg)
`define I2CM_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ----- hw/rtl/i2cm_pkg.sv -----
// Types and constants of the I2C master register access block.
package i2cm_pkg;

    localparam int DELAY_WIDTH = 16;
    localparam int ADDR_WIDTH  = 7;
    localparam int PADDR_WIDTH = 3;

    localparam logic [ADDR_WIDTH-1:0]  DEV_ADDR_RESET = 7'd104;
    localparam logic [DELAY_WIDTH-1:0] DELAY_RESET    = 16'd100;

    localparam logic [PADDR_WIDTH-1:0] REG_DEV_ADDR = 3'd0;
    localparam logic [PADDR_WIDTH-1:0] REG_DELAY    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUS_BUSY = 2'd1;
    localparam logic [1:0] ST_NO_ACK   = 2'd2;

    typedef struct packed {
        logic       request;
        logic       func;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0]  device_address;
        logic [DELAY_WIDTH-1:0] delay_ticks;
    } t_cfg;

endpackage

// ----- hw/rtl/i2c_master_register_access.sv -----
// I2C master register access: one stream transfer per bus timing tick.
// A transfer is held in the input register, and its result in the output register.
// Throughput: one transfer per cycle in and out; while a result waits, the input
// register takes one more transfer, then tready drops until the output drains.
// Each bus step lasts delay_ticks transfers (zero counts as one).
// Reset (synchronous, active low): idle, both lines released, registers at defaults.
module i2c_master_register_access (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // APB configuration port: 0x0 device_address, 0x4 delay_ticks
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cm_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [0] request, [1] func, [9:2] reg_addr, [17:10] wr_data, [18] sda_in
    input  logic [23:0]                      s_axis_tdata,
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
    //        [11:4] read_data, [13:12] status
    output logic [15:0]                      m_axis_tdata
);
    import i2cm_pkg::*;
    `include "i2c_master_register_access_macros.svh"

    t_cfg    w_cfg;
    t_item   w_item;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result w_res;
    t_result r_out_res;
    logic    r_out_valid;
    logic    w_advance;
    logic    w_fire;
    logic    w_accept;

    i2cm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Unpack the incoming transfer.
    assign w_item.request  = s_axis_tdata[0];
    assign w_item.func     = s_axis_tdata[1];
    assign w_item.reg_addr = s_axis_tdata[9:2];
    assign w_item.wr_data  = s_axis_tdata[17:10];
    assign w_item.sda_in   = s_axis_tdata[18];

    // Advance the pipe when the output register is free or being drained.
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Capture payload on accept only.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= w_item;
        end
    end

    // One tick of the sequencer per fired item; state moves only on fire.
    i2cm_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_res.status, r_out_res.read_data,
                            r_out_res.done_res, r_out_res.busy_res,
                            r_out_res.sda_release, r_out_res.scl_release};

    // An accepted transfer always lands in the input register.
    `I2CM_ASSERT(a_in_loaded, i_clk, i_rst_n, w_accept |=> r_in_valid, "input transfer lost")
    // A fired item always produces a waiting result.
    `I2CM_ASSERT(a_out_loaded, i_clk, i_rst_n, w_fire |=> r_out_valid, "result lost")
    // A stalled input item stays put until the output side frees up.
    `I2CM_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_valid && !w_advance) |=> r_in_valid,
        "stalled item dropped")
    // A finishing tick leaves the master idle.
    `I2CM_NEVER(a_done_busy, i_clk, i_rst_n, w_fire && w_res.done_res && w_res.busy_res,
        "done while busy")

endmodule

// ----- hw/rtl/i2cm_cfg.sv -----
// APB register file: device address and bus step length.
module i2cm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cm_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output i2cm_pkg::t_cfg                   o_cfg
);
    import i2cm_pkg::*;

    logic [ADDR_WIDTH-1:0]  r_dev_addr;
    logic [DELAY_WIDTH-1:0] r_delay;
    logic                   w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
            r_delay    <= DELAY_RESET;
        end else if (w_wr) begin
            if (paddr == REG_DEV_ADDR) begin
                r_dev_addr <= pwdata[ADDR_WIDTH-1:0];
            end
            if (paddr == REG_DELAY) begin
                r_delay <= pwdata[DELAY_WIDTH-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_DEV_ADDR) begin
            prdata[ADDR_WIDTH-1:0] = r_dev_addr;
        end else if (paddr == REG_DELAY) begin
            prdata[DELAY_WIDTH-1:0] = r_delay;
        end
    end

    assign o_cfg.device_address = r_dev_addr;
    assign o_cfg.delay_ticks    = r_delay;

endmodule

// ----- hw/rtl/i2cm_engine.sv -----
// Bus sequencer: advances the I2C transaction by one tick per item.
module i2cm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  i2cm_pkg::t_item   i_item,
    input  i2cm_pkg::t_cfg    i_cfg,
    output i2cm_pkg::t_result o_res
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TX_A, PH_TX_B, PH_TX_C,
        PH_AK_A, PH_AK_B, PH_AK_C, PH_RX_B, PH_RX_C,
        PH_NK_0, PH_NK_1, PH_NK_2, PH_NK_3, PH_NK_4,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D
    } t_phase;

    typedef enum logic [2:0] {
        SG_ADDR_W, SG_REG, SG_DATA, SG_RESTART, SG_ADDR_R, SG_RECV
    } t_stage;

    t_phase                 r_phase, n_phase;
    t_stage                 r_stage, n_stage;
    logic [2:0]             r_bit, n_bit;
    logic [7:0]             r_shift, n_shift;
    logic [DELAY_WIDTH-1:0] r_delay, n_delay;
    logic                   r_is_read, n_is_read;
    logic [7:0]             r_reg, n_reg;
    logic [7:0]             r_wbyte, n_wbyte;
    logic [7:0]             r_last_read, n_last_read;
    logic [1:0]             r_last_status, n_last_status;
    logic [1:0]             r_pending, n_pending;
    logic                   r_nack, n_nack;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;
    logic                   n_done;

    logic                   v_go;
    logic                   v_fin;
    logic [1:0]             v_fin_st;
    t_phase                 v_tgt;
    logic [DELAY_WIDTH-1:0] w_step_len;
    logic [DELAY_WIDTH-1:0] w_dec;
    logic [7:0]             w_addr_w;
    logic [7:0]             w_addr_r;

    // A step length of zero behaves as one tick.
    assign w_step_len = (i_cfg.delay_ticks == '0) ? DELAY_WIDTH'(1) : i_cfg.delay_ticks;
    assign w_dec      = (r_delay != '0) ? r_delay - DELAY_WIDTH'(1) : '0;
    assign w_addr_w   = {i_cfg.device_address, 1'b0};
    assign w_addr_r   = {i_cfg.device_address, 1'b1};

    always_comb begin
        n_phase       = r_phase;
        n_stage       = r_stage;
        n_bit         = r_bit;
        n_shift       = r_shift;
        n_delay       = r_delay;
        n_is_read     = r_is_read;
        n_reg         = r_reg;
        n_wbyte       = r_wbyte;
        n_last_read   = r_last_read;
        n_last_status = r_last_status;
        n_pending     = r_pending;
        n_nack        = r_nack;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_done        = 1'b0;
        v_go          = 1'b0;
        v_fin         = 1'b0;
        v_fin_st      = ST_OK;
        v_tgt         = PH_IDLE;

        if (r_phase == PH_IDLE) begin
            if (i_item.request) begin
                n_is_read = i_item.func;
                n_reg     = i_item.reg_addr;
                n_wbyte   = i_item.wr_data;
                n_stage   = SG_ADDR_W;
                n_nack    = 1'b0;
                n_pending = ST_OK;
                v_go      = 1'b1;
                v_tgt     = PH_ST_A;
            end
        end else begin
            n_delay = w_dec;
            if (w_dec == '0) begin
                unique case (r_phase)
                    PH_ST_A: begin
                        v_go = 1'b1; v_tgt = PH_ST_B;
                    end
                    PH_ST_B: begin
                        if (!i_item.sda_in) begin
                            if (r_stage == SG_ADDR_W) begin
                                v_fin = 1'b1; v_fin_st = ST_BUS_BUSY;
                            end else begin
                                // Repeated start with SDA already low: skip the low step.
                                n_stage = SG_ADDR_R;
                                n_shift = w_addr_r;
                                n_bit   = '0;
                                v_go = 1'b1; v_tgt = PH_TX_A;
                            end
                        end else begin
                            v_go = 1'b1; v_tgt = PH_ST_C;
                        end
                    end
                    PH_ST_C: begin
                        if (r_stage == SG_ADDR_W) begin
                            if (i_item.sda_in) begin
                                v_fin = 1'b1; v_fin_st = ST_BUS_BUSY;
                            end else begin
                                n_shift = w_addr_w;
                                n_bit   = '0;
                                v_go = 1'b1; v_tgt = PH_TX_A;
                            end
                        end else begin
                            n_stage = SG_ADDR_R;
                            n_shift = w_addr_r;
                            n_bit   = '0;
                            v_go = 1'b1; v_tgt = PH_TX_A;
                        end
                    end
                    PH_TX_A: begin
                        v_go = 1'b1; v_tgt = PH_TX_B;
                    end
                    PH_TX_B: begin
                        v_go = 1'b1; v_tgt = PH_TX_C;
                    end
                    PH_TX_C: begin
                        n_shift = {r_shift[6:0], 1'b0};
                        v_go    = 1'b1;
                        if (r_bit == 3'd7) begin
                            n_bit = '0; v_tgt = PH_AK_A;
                        end else begin
                            n_bit = r_bit + 3'd1; v_tgt = PH_TX_A;
                        end
                    end
                    PH_AK_A: begin
                        v_go = 1'b1; v_tgt = PH_AK_B;
                    end
                    PH_AK_B: begin
                        n_nack = i_item.sda_in;
                        v_go = 1'b1; v_tgt = PH_AK_C;
                    end
                    PH_AK_C: begin
                        v_go = 1'b1;
                        if (r_stage == SG_ADDR_W) begin
                            if (r_nack) begin
                                n_pending = ST_NO_ACK; v_tgt = PH_SP_A;
                            end else begin
                                n_stage = SG_REG;
                                n_shift = r_reg;
                                n_bit   = '0;
                                v_tgt   = PH_TX_A;
                            end
                        end else if (r_stage == SG_REG) begin
                            if (r_is_read) begin
                                n_stage = SG_RESTART; v_tgt = PH_ST_A;
                            end else begin
                                n_stage = SG_DATA;
                                n_shift = r_wbyte;
                                n_bit   = '0;
                                v_tgt   = PH_TX_A;
                            end
                        end else if (r_stage == SG_DATA) begin
                            n_pending = ST_OK; v_tgt = PH_SP_A;
                        end else begin
                            n_stage = SG_RECV;
                            n_shift = '0;
                            n_bit   = '0;
                            v_tgt   = PH_RX_B;
                        end
                    end
                    PH_RX_B: begin
                        n_shift = {r_shift[6:0], i_item.sda_in};
                        v_go = 1'b1; v_tgt = PH_RX_C;
                    end
                    PH_RX_C: begin
                        v_go = 1'b1;
                        if (r_bit == 3'd7) begin
                            n_bit       = '0;
                            n_last_read = r_shift;
                            v_tgt       = PH_NK_0;
                        end else begin
                            n_bit = r_bit + 3'd1; v_tgt = PH_RX_B;
                        end
                    end
                    PH_NK_0: begin
                        v_go = 1'b1; v_tgt = PH_NK_1;
                    end
                    PH_NK_1: begin
                        v_go = 1'b1; v_tgt = PH_NK_2;
                    end
                    PH_NK_2: begin
                        v_go = 1'b1; v_tgt = PH_NK_3;
                    end
                    PH_NK_3: begin
                        v_go = 1'b1; v_tgt = PH_NK_4;
                    end
                    PH_NK_4: begin
                        n_pending = ST_OK; v_go = 1'b1; v_tgt = PH_SP_A;
                    end
                    PH_SP_A: begin
                        v_go = 1'b1; v_tgt = PH_SP_B;
                    end
                    PH_SP_B: begin
                        v_go = 1'b1; v_tgt = PH_SP_C;
                    end
                    PH_SP_C: begin
                        v_go = 1'b1; v_tgt = PH_SP_D;
                    end
                    PH_SP_D: begin
                        v_fin = 1'b1; v_fin_st = r_pending;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        if (v_fin) begin
            n_last_status = v_fin_st;
            if (r_is_read && (v_fin_st != ST_OK)) begin
                n_last_read = '0;
            end
            n_phase = PH_IDLE;
            n_delay = '0;
            n_done  = 1'b1;
        end

        // Enter the target step: drive its line levels and reload the timer.
        if (v_go) begin
            n_phase = v_tgt;
            n_delay = w_step_len;
            unique case (v_tgt)
                PH_ST_A: n_sda = 1'b1;
                PH_ST_B: n_scl = 1'b1;
                PH_ST_C: n_sda = 1'b0;
                PH_TX_A: begin
                    n_scl = 1'b0;
                    n_sda = n_shift[7];
                end
                PH_TX_B: n_scl = 1'b1;
                PH_TX_C: n_scl = 1'b0;
                PH_AK_A: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                end
                PH_AK_B: n_scl = 1'b1;
                PH_AK_C: n_scl = 1'b0;
                PH_RX_B: n_scl = 1'b1;
                PH_RX_C: n_scl = 1'b0;
                PH_NK_1: n_scl = 1'b0;
                PH_NK_2: n_sda = 1'b1;
                PH_NK_3: n_scl = 1'b1;
                PH_NK_4: n_scl = 1'b0;
                PH_SP_A: n_scl = 1'b0;
                PH_SP_B: n_sda = 1'b0;
                PH_SP_C: n_scl = 1'b1;
                PH_SP_D: n_sda = 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_stage       <= SG_ADDR_W;
            r_bit         <= '0;
            r_shift       <= '0;
            r_delay       <= '0;
            r_is_read     <= 1'b0;
            r_reg         <= '0;
            r_wbyte       <= '0;
            r_last_read   <= '0;
            r_last_status <= ST_OK;
            r_pending     <= ST_OK;
            r_nack        <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_stage       <= n_stage;
            r_bit         <= n_bit;
            r_shift       <= n_shift;
            r_delay       <= n_delay;
            r_is_read     <= n_is_read;
            r_reg         <= n_reg;
            r_wbyte       <= n_wbyte;
            r_last_read   <= n_last_read;
            r_last_status <= n_last_status;
            r_pending     <= n_pending;
            r_nack        <= n_nack;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
        end
    end

    assign o_res.scl_release = n_scl;
    assign o_res.sda_release = n_sda;
    assign o_res.busy_res    = (n_phase != PH_IDLE);
    assign o_res.done_res    = n_done;
    assign o_res.read_data   = n_last_read;
    assign o_res.status      = n_last_status;

endmodule

// ----- sim/testbench.sv -----
// Self-checking stream testbench for the I2C master register access block.
module testbench;
    import i2cm_pkg::*;

    // Idle cycles with no transfer on either side before the run is abandoned.
    // The longest legal stretch is the receiver hold-off below.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Bus phases of the master, one per elementary bus step.
    typedef enum logic [4:0] {
        MP_IDLE, MP_START_REL, MP_START_SCL, MP_START_SDA,
        MP_BIT_SET, MP_BIT_HIGH, MP_BIT_LOW,
        MP_ACK_REL, MP_ACK_HIGH, MP_ACK_LOW,
        MP_RX_HIGH, MP_RX_LOW,
        MP_NACK_WAIT, MP_NACK_SCL_LOW, MP_NACK_SDA_REL, MP_NACK_SCL_HIGH, MP_NACK_SCL_DROP,
        MP_STOP_SCL_LOW, MP_STOP_SDA_LOW, MP_STOP_SCL_HIGH, MP_STOP_SDA_REL
    } t_master_phase;

    // Which byte of the access the master is working on.
    typedef enum logic [2:0] {
        SEG_ADDR_WR, SEG_REG, SEG_DATA, SEG_RESTART, SEG_ADDR_RD, SEG_RECV
    } t_access_seg;

    // How the emulated slave and bus behave during one access.
    typedef enum logic [2:0] {
        FT_CLEAN, FT_NOISE, FT_BUS_LOW, FT_BUS_HIGH, FT_ADDR_NACK, FT_RESTART_LOW, FT_RESTART_HIGH
    } t_bus_fault;

    typedef struct {
        t_item   item;
        t_result want;
    } t_tick_rec;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [PADDR_WIDTH-1:0] paddr         = '0;
    logic [31:0]            pwdata        = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: [0] request, [1] func, [9:2] reg_addr, [17:10] wr_data, [18] sda_in
    logic [23:0]            s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
    //        [11:4] read_data, [13:12] status
    logic [15:0]            m_axis_tdata;

    i2c_master_register_access DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted master: configuration mirror and bus state
    // ------------------------------------------------------------------
    logic [6:0]    cfg_dev   = DEV_ADDR_RESET;
    logic [15:0]   cfg_delay = DELAY_RESET;

    t_master_phase mst_phase   = MP_IDLE;
    t_access_seg   mst_seg     = SEG_ADDR_WR;
    logic [2:0]    mst_bit     = '0;
    logic [7:0]    mst_shift   = '0;
    logic [15:0]   mst_ticks   = '0;
    logic          mst_is_read = 1'b0;
    logic [7:0]    mst_reg     = '0;
    logic [7:0]    mst_wbyte   = '0;
    logic [7:0]    mst_rx      = '0;
    logic [1:0]    mst_status  = ST_OK;
    logic [1:0]    mst_pend    = ST_OK;
    logic          mst_nack    = 1'b0;
    logic          mst_scl     = 1'b1;
    logic          mst_sda     = 1'b1;
    logic          mst_done    = 1'b0;

    // Emulated slave for the access in progress.
    t_bus_fault    slave_fault = FT_CLEAN;
    logic [7:0]    slave_byte  = '0;

    t_tick_rec     tick_q[$];
    t_result       expected_lines[$];
    t_tick_rec     cur_tick;
    int            queued_items = 0;
    int            results_seen = 0;
    int            error_count  = 0;

    bit            in_fire    = 1'b0;
    bit            out_fire   = 1'b0;
    bit            steady     = 1'b0;
    bit            src_calm   = 1'b0;
    bit            sink_calm  = 1'b0;
    int            src_gap    = 0;
    int            sink_gap   = 0;
    bit            hold_armed = 1'b0;
    int            hold_from  = 0;
    int            hold_left  = 0;

    // A zero delay still lasts one tick.
    function automatic logic [15:0] step_len();
        return (cfg_delay == '0) ? 16'd1 : cfg_delay;
    endfunction

    // Move to a bus phase, set the line levels it drives and restart the step timer.
    function automatic void enter_phase(t_master_phase p);
        mst_phase = p;
        case (p)
            MP_START_REL: mst_sda = 1'b1;
            MP_START_SCL: mst_scl = 1'b1;
            MP_START_SDA: mst_sda = 1'b0;
            MP_BIT_SET: begin
                mst_scl = 1'b0;
                mst_sda = mst_shift[7];
            end
            MP_BIT_HIGH, MP_ACK_HIGH, MP_RX_HIGH, MP_NACK_SCL_HIGH, MP_STOP_SCL_HIGH:
                mst_scl = 1'b1;
            MP_BIT_LOW, MP_ACK_LOW, MP_RX_LOW, MP_NACK_SCL_LOW, MP_NACK_SCL_DROP,
            MP_STOP_SCL_LOW:
                mst_scl = 1'b0;
            MP_ACK_REL: begin
                mst_scl = 1'b0;
                mst_sda = 1'b1;
            end
            MP_NACK_SDA_REL, MP_STOP_SDA_REL: mst_sda = 1'b1;
            MP_STOP_SDA_LOW: mst_sda = 1'b0;
            default: ;
        endcase
        mst_ticks = step_len();
    endfunction

    function automatic void load_byte(logic [7:0] b);
        mst_shift = b;
        mst_bit   = '0;
        enter_phase(MP_BIT_SET);
    endfunction

    function automatic void close_access(logic [1:0] st);
        mst_status = st;
        if (mst_is_read && st != ST_OK)
            mst_rx = '0;
        mst_phase = MP_IDLE;
        mst_ticks = '0;
        mst_done  = 1'b1;
    endfunction

    function automatic void start_stop(logic [1:0] st);
        mst_pend = st;
        enter_phase(MP_STOP_SCL_LOW);
    endfunction

    // Act on the end of a bus step, with the SDA level sampled on that tick.
    function automatic void step_done(logic sda);
        case (mst_phase)
            MP_START_REL: enter_phase(MP_START_SCL);
            MP_START_SCL: begin
                if (sda == 1'b0) begin
                    // Line held low: fatal at the first start, skips ahead on a restart.
                    if (mst_seg == SEG_ADDR_WR) begin
                        close_access(ST_BUS_BUSY);
                    end else begin
                        mst_seg = SEG_ADDR_RD;
                        load_byte({cfg_dev, FUNC_READ});
                    end
                end else begin
                    enter_phase(MP_START_SDA);
                end
            end
            MP_START_SDA: begin
                if (mst_seg == SEG_ADDR_WR) begin
                    if (sda)
                        close_access(ST_BUS_BUSY);
                    else
                        load_byte({cfg_dev, FUNC_WRITE});
                end else begin
                    mst_seg = SEG_ADDR_RD;
                    load_byte({cfg_dev, FUNC_READ});
                end
            end
            MP_BIT_SET:  enter_phase(MP_BIT_HIGH);
            MP_BIT_HIGH: enter_phase(MP_BIT_LOW);
            MP_BIT_LOW: begin
                mst_shift = mst_shift << 1;
                if (mst_bit == 3'd7) begin
                    mst_bit = '0;
                    enter_phase(MP_ACK_REL);
                end else begin
                    mst_bit = mst_bit + 3'd1;
                    enter_phase(MP_BIT_SET);
                end
            end
            MP_ACK_REL: enter_phase(MP_ACK_HIGH);
            MP_ACK_HIGH: begin
                mst_nack = sda;
                enter_phase(MP_ACK_LOW);
            end
            MP_ACK_LOW: begin
                case (mst_seg)
                    SEG_ADDR_WR: begin
                        if (mst_nack) begin
                            start_stop(ST_NO_ACK);
                        end else begin
                            mst_seg = SEG_REG;
                            load_byte(mst_reg);
                        end
                    end
                    SEG_REG: begin
                        if (mst_is_read) begin
                            mst_seg = SEG_RESTART;
                            enter_phase(MP_START_REL);
                        end else begin
                            mst_seg = SEG_DATA;
                            load_byte(mst_wbyte);
                        end
                    end
                    SEG_DATA: start_stop(ST_OK);
                    default: begin
                        mst_seg   = SEG_RECV;
                        mst_shift = '0;
                        mst_bit   = '0;
                        enter_phase(MP_RX_HIGH);
                    end
                endcase
            end
            MP_RX_HIGH: begin
                mst_shift = {mst_shift[6:0], sda};
                enter_phase(MP_RX_LOW);
            end
            MP_RX_LOW: begin
                if (mst_bit == 3'd7) begin
                    mst_bit = '0;
                    mst_rx  = mst_shift;
                    enter_phase(MP_NACK_WAIT);
                end else begin
                    mst_bit = mst_bit + 3'd1;
                    enter_phase(MP_RX_HIGH);
                end
            end
            MP_NACK_WAIT:     enter_phase(MP_NACK_SCL_LOW);
            MP_NACK_SCL_LOW:  enter_phase(MP_NACK_SDA_REL);
            MP_NACK_SDA_REL:  enter_phase(MP_NACK_SCL_HIGH);
            MP_NACK_SCL_HIGH: enter_phase(MP_NACK_SCL_DROP);
            MP_NACK_SCL_DROP: start_stop(ST_OK);
            MP_STOP_SCL_LOW:  enter_phase(MP_STOP_SDA_LOW);
            MP_STOP_SDA_LOW:  enter_phase(MP_STOP_SCL_HIGH);
            MP_STOP_SCL_HIGH: enter_phase(MP_STOP_SDA_REL);
            MP_STOP_SDA_REL:  close_access(mst_pend);
            default: mst_phase = MP_IDLE;
        endcase
    endfunction

    // Advance the predicted master by one tick and return the line and status word.
    function automatic t_result master_tick(t_item it);
        t_result r;
        mst_done = 1'b0;
        if (mst_phase == MP_IDLE) begin
            if (it.request) begin
                mst_is_read = it.func;
                mst_reg     = it.reg_addr;
                mst_wbyte   = it.wr_data;
                mst_seg     = SEG_ADDR_WR;
                mst_nack    = 1'b0;
                mst_pend    = ST_OK;
                enter_phase(MP_START_REL);
            end
        end else begin
            if (mst_ticks != '0)
                mst_ticks = mst_ticks - 16'd1;
            if (mst_ticks == '0)
                step_done(it.sda_in);
        end
        r.scl_release = mst_scl;
        r.sda_release = mst_sda;
        r.busy_res    = (mst_phase != MP_IDLE);
        r.done_res    = mst_done;
        r.read_data   = mst_rx;
        r.status      = mst_status;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: the SDA level seen on the bus, from the master's own drive
    // plus the slave's ACKs, data bits and the faults of this access
    // ------------------------------------------------------------------
    function automatic logic slave_line();
        logic v;
        v = mst_sda;
        case (mst_phase)
            MP_IDLE: v = 1'($urandom_range(0, 1));
            MP_START_SCL:
                if ((slave_fault == FT_BUS_LOW && mst_seg == SEG_ADDR_WR) ||
                    (slave_fault == FT_RESTART_LOW && mst_seg == SEG_RESTART))
                    v = 1'b0;
            MP_START_SDA:
                if ((slave_fault == FT_BUS_HIGH && mst_seg == SEG_ADDR_WR) ||
                    (slave_fault == FT_RESTART_HIGH && mst_seg == SEG_RESTART))
                    v = 1'b1;
            // Address ACK decides the access; the other ACKs are random and ignored.
            MP_ACK_HIGH:
                if (mst_seg == SEG_ADDR_WR)
                    v = (slave_fault == FT_ADDR_NACK);
                else
                    v = ($urandom_range(0, 3) == 0);
            MP_RX_HIGH: v = slave_byte[3'd7 - mst_bit];
            default: ;
        endcase
        if (slave_fault == FT_NOISE && $urandom_range(0, 15) == 0)
            v = ~v;
        return v;
    endfunction

    // Queue one tick for the driver together with its predicted result.
    function automatic void queue_tick(logic req, logic fn, logic [7:0] ra, logic [7:0] wd);
        t_tick_rec t;
        t.item.request  = req;
        t.item.func     = fn;
        t.item.reg_addr = ra;
        t.item.wr_data  = wd;
        t.item.sda_in   = slave_line();
        t.want          = master_tick(t.item);
        tick_q.push_back(t);
        queued_items++;
    endfunction

    // Request one access and keep ticking until it ends; requests made while
    // busy carry random fields and must be ignored.
    function automatic void one_access(logic fn, logic [7:0] ra, logic [7:0] wd,
                                       t_bus_fault f, logic [7:0] rx);
        slave_fault = f;
        slave_byte  = rx;
        queue_tick(1'b1, fn, ra, wd);
        while (mst_phase != MP_IDLE)
            queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    function automatic t_bus_fault pick_fault();
        int k;
        k = $urandom_range(0, 12);
        return (k > 6) ? FT_CLEAN : t_bus_fault'(k);
    endfunction

    // Mostly complete accesses with random content, with idle ticks between them.
    function automatic void random_traffic(int n);
        int first;
        first = queued_items;
        while (queued_items - first < n) begin
            if ($urandom_range(0, 2) == 0)
                one_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), pick_fault(),
                           8'($urandom_range(0, 255)));
            else
                queue_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        end
    endfunction

    // Wait count before the next transfer; flip now and then between idling
    // and back-to-back stretches.
    function automatic int pick_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = ~calm;
        return (calm || steady) ? 0 : $urandom_range(0, 16);
    endfunction

    // Register write: setup cycle, then access cycle until pready.
    task automatic cfg_write(logic [PADDR_WIDTH-1:0] addr, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_DEV_ADDR)
            cfg_dev = value[6:0];
        else if (addr == REG_DELAY)
            cfg_delay = value[15:0];
    endtask

    // Hold until every queued tick is accepted and every result is back.
    task automatic wait_drained();
        while (tick_q.size() != 0 || s_axis_tvalid || expected_lines.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued ticks at the falling edge; record the expected
    // result once a transfer has been accepted
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : feed_ticks
        logic offer;
        offer = s_axis_tvalid;
        if (!i_rst_n) begin
            offer = 1'b0;
        end else begin
            if (in_fire) begin
                expected_lines.push_back(cur_tick.want);
                offer   = 1'b0;
                src_gap = pick_gap(src_calm);
            end
            if (!offer) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (tick_q.size() != 0) begin
                    cur_tick = tick_q.pop_front();
                    s_axis_tdata <= {5'd0, cur_tick.item.sda_in, cur_tick.item.wr_data,
                                     cur_tick.item.reg_addr, cur_tick.item.func,
                                     cur_tick.item.request};
                    offer = 1'b1;
                end
            end
        end
        s_axis_tvalid <= offer;
    end

    // Receiver pacing: random wait per result, plus one long hold-off that
    // lets the block fill up and back-pressure its input.
    always @(negedge i_clk) begin : pace_results
        logic take;
        take = m_axis_tready;
        if (!i_rst_n) begin
            take = 1'b0;
        end else begin
            if (hold_armed && results_seen >= hold_from) begin
                hold_armed = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (out_fire) begin
                take     = 1'b0;
                sink_gap = pick_gap(sink_calm);
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (!take) begin
                if (sink_gap > 0)
                    sink_gap--;
                else
                    take = 1'b1;
            end
        end
        m_axis_tready <= take;
    end

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            if (error_count < 10)
                $display("ERROR result %0d: %s expected %0d, got %0d",
                         results_seen, field, want, got);
            error_count++;
        end
    endfunction

    // Monitor: note both handshakes at the rising edge and compare each
    // result against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result want;
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (out_fire) begin
            results_seen++;
            if (expected_lines.size() == 0) begin
                if (error_count < 10)
                    $display("ERROR result %0d: 0x%h arrived with nothing pending",
                             results_seen, m_axis_tdata);
                error_count++;
            end else begin
                want = expected_lines.pop_front();
                check_field("scl_release", int'(want.scl_release), int'(m_axis_tdata[0]));
                check_field("sda_release", int'(want.sda_release), int'(m_axis_tdata[1]));
                check_field("busy_res",    int'(want.busy_res),    int'(m_axis_tdata[2]));
                check_field("done_res",    int'(want.done_res),    int'(m_axis_tdata[3]));
                check_field("read_data",   int'(want.read_data),   int'(m_axis_tdata[11:4]));
                check_field("status",      int'(want.status),      int'(m_axis_tdata[13:12]));
            end
        end
    end

    // Watchdog: abandon the run after a long stretch with no transfer at all.
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: a read whose first start sees the bus held low,
        // ending after two steps of the default delay with bus-busy status.
        one_access(FUNC_READ, 8'hFF, 8'h00, FT_BUS_LOW, 8'h00);
        wait_drained();

        // Directed accesses at the top device address and the shortest delay.
        cfg_write(REG_DEV_ADDR, 32'h7F);
        cfg_write(REG_DELAY, 32'd1);
        one_access(FUNC_WRITE, 8'hFF, 8'h00, FT_CLEAN, 8'h00);
        one_access(FUNC_WRITE, 8'h00, 8'hFF, FT_CLEAN, 8'h00);
        one_access(FUNC_READ,  8'h5A, 8'h00, FT_CLEAN, 8'hFF);
        // Restart sees SDA low: the SDA-low step is skipped, read goes on.
        one_access(FUNC_READ,  8'h00, 8'hFF, FT_RESTART_LOW, 8'h00);
        // Restart sees SDA high after driving it low: not an error.
        one_access(FUNC_READ,  8'hA5, 8'h3C, FT_RESTART_HIGH, 8'hA5);
        // A write keeps the last read byte.
        one_access(FUNC_WRITE, 8'h81, 8'h7E, FT_BUS_LOW, 8'h00);
        one_access(FUNC_READ,  8'h42, 8'h00, FT_BUS_HIGH, 8'h00);
        one_access(FUNC_WRITE, 8'h10, 8'h20, FT_ADDR_NACK, 8'h00);
        // A read that fails clears the read byte.
        one_access(FUNC_READ,  8'h33, 8'h00, FT_ADDR_NACK, 8'h00);
        one_access(FUNC_READ,  8'hC3, 8'h00, FT_NOISE, 8'h96);
        wait_drained();

        // Zero device address, zero delay (acts as one tick).
        cfg_write(REG_DEV_ADDR, 32'h00);
        cfg_write(REG_DELAY, 32'd0);
        random_traffic(150);
        wait_drained();

        // Random address, two ticks per step; hold off the receiver once.
        cfg_write(REG_DEV_ADDR, $urandom_range(0, 127));
        cfg_write(REG_DELAY, 32'd2);
        hold_from  = results_seen + 50;
        hold_armed = 1'b1;
        random_traffic(150);
        wait_drained();

        cfg_write(REG_DEV_ADDR, $urandom_range(0, 127));
        cfg_write(REG_DELAY, 32'd3);
        random_traffic(150);
        wait_drained();

        // Longest delay: the first step alone outlasts the run, so send a request
        // and a short back-to-back burst while the master is still busy.
        cfg_write(REG_DEV_ADDR, 32'h68);
        cfg_write(REG_DELAY, 32'hFFFF);
        steady      = 1'b1;
        slave_fault = FT_CLEAN;
        queue_tick(1'b1, FUNC_WRITE, 8'h6B, 8'h01);
        repeat (40)
            queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
